FILE: sv/rct_pkg.sv
// Shared constants, types and codes for the reference count table.
package rct_pkg;

   localparam int TABLE_DEPTH       = 16;
   localparam int ADDR_WIDTH        = 32;
   localparam int COUNT_WIDTH       = 16;
   localparam int FIELD_ADDR_WIDTH  = 32;
   localparam int FIELD_TALLY_WIDTH = 5;
   localparam int IDX_WIDTH         = $clog2(TABLE_DEPTH);
   localparam int LIVE_WIDTH        = $clog2(TABLE_DEPTH + 1);

   typedef logic [ADDR_WIDTH-1:0]        addr_type;
   typedef logic [COUNT_WIDTH-1:0]       count_type;
   typedef logic [IDX_WIDTH-1:0]         idx_type;
   typedef logic [LIVE_WIDTH-1:0]        live_type;
   typedef logic [FIELD_ADDR_WIDTH-1:0]  field_addr_type;
   typedef logic [FIELD_TALLY_WIDTH-1:0] tally_type;

   localparam count_type COUNT_MAX = '1;
   localparam idx_type   IDX_LAST  = idx_type'(TABLE_DEPTH - 1);

   typedef enum logic [1:0] {
      ACT_ASSIGN = 2'd0,
      ACT_ALLOC  = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_DUP  = 2'd2,
      ST_SAT  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_INSERT,
      S_FINISH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic    load;
      logic    scan;
      idx_type idx;
      logic    insert;
      logic    emit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_alloc;
      logic out_free;
   } stat_type;

endpackage

FILE: sv/rct_req_if.sv
// Request channel: valid/ready handshake with the table operation payload.
interface rct_req_if
   import rct_pkg::*;
();
   logic           valid;
   logic           ready;
   action_type     action;
   field_addr_type old_addr;
   logic           release_old;
   field_addr_type new_addr;

   modport source (output valid, output action, output old_addr, output release_old,
                   output new_addr, input ready);
   modport sink   (input valid, input action, input old_addr, input release_old,
                   input new_addr, output ready);
endinterface

FILE: sv/rct_rsp_if.sv
// Response channel: valid/ready handshake with the per-transaction result.
interface rct_rsp_if
   import rct_pkg::*;
();
   logic           valid;
   logic           ready;
   status_type     status;
   field_addr_type result_addr;
   logic           freed_valid;
   field_addr_type freed_addr;
   tally_type      live_entries;
   tally_type      dropped_count;

   modport source (output valid, output status, output result_addr, output freed_valid,
                   output freed_addr, output live_entries, output dropped_count,
                   input ready);
   modport sink   (input valid, input status, input result_addr, input freed_valid,
                   input freed_addr, input live_entries, input dropped_count,
                   output ready);
endinterface

FILE: sv/reference_count_table_core.sv
// Top level of the reference count table: controller, datapath and channel hookup.
//
// Tracks up to TABLE_DEPTH addresses, each with a saturating reference count.
// Every request transaction yields exactly one response transaction. Requests
// are handled one at a time: each is accepted, then an assign scans all
// TABLE_DEPTH entries and loads the result, an allocate also writes the new
// entry after the scan, and a clear or no-op loads its result directly.
// During a scan the datapath visits one table entry per cycle to
// decrement, increment, sweep a zeroed entry, check for a duplicate and find
// the lowest free slot, all in the same pass. The result sits in an output
// register, so a finished response may wait on rsp_chan.ready while the next
// request is taken; a new result is loaded only once the old one has left.
// Only the entry whose count reaches zero is reported in freed_addr. Address
// zero means "none" and never matches an entry. There is no clearing pass:
// the valid bits are cleared at reset and by a clear transaction.
module reference_count_table_core
   import rct_pkg::*;
(
   input logic       clock,
   input logic       reset,
   rct_req_if.sink   req_chan,
   rct_rsp_if.source rsp_chan
);

   cmd_type  cmd;
   stat_type stat;

   // sequencing
   rct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // table storage, scan logic and result register
   rct_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req_chan.action),
      .req_old_addr      (req_chan.old_addr),
      .req_release_old   (req_chan.release_old),
      .req_new_addr      (req_chan.new_addr),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_status        (rsp_chan.status),
      .rsp_result_addr   (rsp_chan.result_addr),
      .rsp_freed_valid   (rsp_chan.freed_valid),
      .rsp_freed_addr    (rsp_chan.freed_addr),
      .rsp_live_entries  (rsp_chan.live_entries),
      .rsp_dropped_count (rsp_chan.dropped_count)
   );

endmodule

FILE: sv/rct_ctrl.sv
// Controller FSM: sequences accept, table scan, insert and result hand-off.
module rct_ctrl
   import rct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  action_type req_action,
   output logic       req_ready,
   input  stat_type   stat,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   idx_type   idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (req_valid) begin
               if (req_action inside {ACT_ASSIGN, ACT_ALLOC}) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) begin
               state_in = stat.is_alloc ? S_INSERT : S_FINISH;
            end
         end
         S_INSERT: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.idx    = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
         end
         S_FINISH: begin
            cmd.emit = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

FILE: sv/rct_dpath.sv
// Datapath: entry table, per-entry scan update, insert and result register.
module rct_dpath
   import rct_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cmd_type        cmd,
   output stat_type       stat,
   input  action_type     req_action,
   input  field_addr_type req_old_addr,
   input  logic           req_release_old,
   input  field_addr_type req_new_addr,
   input  logic           rsp_ready,
   output logic           rsp_valid,
   output status_type     rsp_status,
   output field_addr_type rsp_result_addr,
   output logic           rsp_freed_valid,
   output field_addr_type rsp_freed_addr,
   output tally_type      rsp_live_entries,
   output tally_type      rsp_dropped_count
);

   // latched transaction
   action_type op_ff, op_in;
   logic       rel_ff, rel_in;
   addr_type   old_ff, old_in;
   addr_type   new_ff, new_in;

   // table
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   addr_type               addr_ff  [TABLE_DEPTH];
   count_type              count_ff [TABLE_DEPTH];
   live_type               live_ff, live_in;

   // scan results
   logic     sat_ff, sat_in;
   logic     dup_ff, dup_in;
   logic     freed_ff, freed_in;
   addr_type freed_addr_ff, freed_addr_in;
   logic     slot_found_ff, slot_found_in;
   idx_type  slot_ff, slot_in;

   // result register
   logic           rsp_valid_ff, rsp_valid_in;
   status_type     rsp_status_ff, rsp_status_in;
   field_addr_type rsp_result_addr_ff, rsp_result_addr_in;
   logic           rsp_freed_valid_ff, rsp_freed_valid_in;
   field_addr_type rsp_freed_addr_ff, rsp_freed_addr_in;
   tally_type      rsp_live_ff, rsp_live_in;
   tally_type      rsp_dropped_ff, rsp_dropped_in;

   logic      is_assign, is_alloc, is_clear, sweep_en;
   logic      cur_valid;
   addr_type  cur_addr;
   count_type cur_count, cnt_dec, cnt_upd;
   logic      hit_old, hit_new, sat_hit, frees, valid_after, dup_hit;
   logic      ins_ok;
   logic      wr_en, addr_wr_en;
   idx_type   wr_idx;
   count_type count_in;

   assign is_assign = (op_ff == ACT_ASSIGN);
   assign is_alloc  = (op_ff == ACT_ALLOC);
   assign is_clear  = (op_ff == ACT_CLEAR);
   assign sweep_en  = is_assign || (is_alloc && rel_ff);

   // one entry per scan cycle
   assign cur_valid = valid_ff[cmd.idx];
   assign cur_addr  = addr_ff[cmd.idx];
   assign cur_count = count_ff[cmd.idx];

   always_comb begin
      hit_old     = sweep_en && cur_valid && (old_ff != '0) && (cur_addr == old_ff);
      hit_new     = is_assign && cur_valid && (new_ff != '0) && (cur_addr == new_ff);
      cnt_dec     = (hit_old && (cur_count != '0)) ? cur_count - 1'b1 : cur_count;
      sat_hit     = hit_new && (cnt_dec == COUNT_MAX);
      cnt_upd     = (hit_new && !sat_hit) ? cnt_dec + 1'b1 : cnt_dec;
      frees       = sweep_en && cur_valid && (cnt_upd == '0);
      valid_after = cur_valid && !frees;
      dup_hit     = is_alloc && (new_ff != '0) && valid_after && (cur_addr == new_ff);
   end

   assign ins_ok = cmd.insert && is_alloc && (new_ff != '0) && !dup_ff && slot_found_ff;

   // table write port
   assign wr_en      = (cmd.scan && cur_valid) || ins_ok;
   assign addr_wr_en = ins_ok;
   assign wr_idx     = cmd.insert ? slot_ff : cmd.idx;
   assign count_in   = cmd.insert ? count_type'(1) : cnt_upd;

   always_comb begin
      valid_in = valid_ff;
      live_in  = live_ff;
      if (cmd.scan && frees) begin
         valid_in[cmd.idx] = 1'b0;
         live_in           = live_ff - 1'b1;
      end
      if (ins_ok) begin
         valid_in[slot_ff] = 1'b1;
         live_in           = live_ff + 1'b1;
      end
      if (cmd.emit && is_clear) begin
         valid_in = '0;
         live_in  = '0;
      end
   end

   // transaction capture and scan flags
   always_comb begin
      op_in         = op_ff;
      rel_in        = rel_ff;
      old_in        = old_ff;
      new_in        = new_ff;
      sat_in        = sat_ff;
      dup_in        = dup_ff;
      freed_in      = freed_ff;
      freed_addr_in = freed_addr_ff;
      slot_found_in = slot_found_ff;
      slot_in       = slot_ff;
      if (cmd.load) begin
         op_in         = req_action;
         rel_in        = req_release_old;
         old_in        = addr_type'(req_old_addr);
         new_in        = addr_type'(req_new_addr);
         sat_in        = 1'b0;
         dup_in        = 1'b0;
         freed_in      = 1'b0;
         slot_found_in = 1'b0;
      end else if (cmd.scan) begin
         sat_in = sat_ff || sat_hit;
         dup_in = dup_ff || dup_hit;
         if (frees) begin
            freed_in      = 1'b1;
            freed_addr_in = cur_addr;
         end
         // lowest free slot, judged after the sweep
         if (!valid_after && !slot_found_ff) begin
            slot_found_in = 1'b1;
            slot_in       = cmd.idx;
         end
      end
   end

   // result assembly
   always_comb begin
      rsp_status_in = ST_OK;
      case (op_ff)
         ACT_ASSIGN: rsp_status_in = sat_ff ? ST_SAT : ST_OK;
         ACT_ALLOC: begin
            if (new_ff == '0) begin
               rsp_status_in = ST_OK;
            end else if (dup_ff) begin
               rsp_status_in = ST_DUP;
            end else if (!slot_found_ff) begin
               rsp_status_in = ST_FULL;
            end
         end
         default: rsp_status_in = ST_OK;
      endcase
      rsp_result_addr_in = (is_assign || is_alloc) ? field_addr_type'(new_ff) : '0;
      rsp_freed_valid_in = freed_ff;
      rsp_freed_addr_in  = freed_ff ? field_addr_type'(freed_addr_ff) : '0;
      rsp_live_in        = is_clear ? '0 : tally_type'(live_ff);
      rsp_dropped_in     = is_clear ? tally_type'(live_ff) : '0;
   end

   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         live_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         sat_ff        <= 1'b0;
         dup_ff        <= 1'b0;
         freed_ff      <= 1'b0;
         slot_found_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         live_ff       <= live_in;
         rsp_valid_ff  <= rsp_valid_in;
         sat_ff        <= sat_in;
         dup_ff        <= dup_in;
         freed_ff      <= freed_in;
         slot_found_ff <= slot_found_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      rel_ff        <= rel_in;
      old_ff        <= old_in;
      new_ff        <= new_in;
      freed_addr_ff <= freed_addr_in;
      slot_ff       <= slot_in;
      if (wr_en) begin
         count_ff[wr_idx] <= count_in;
      end
      if (addr_wr_en) begin
         addr_ff[wr_idx] <= new_ff;
      end
      if (cmd.emit) begin
         rsp_status_ff      <= rsp_status_in;
         rsp_result_addr_ff <= rsp_result_addr_in;
         rsp_freed_valid_ff <= rsp_freed_valid_in;
         rsp_freed_addr_ff  <= rsp_freed_addr_in;
         rsp_live_ff        <= rsp_live_in;
         rsp_dropped_ff     <= rsp_dropped_in;
      end
   end

   assign stat.is_alloc = is_alloc;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_addr   = rsp_result_addr_ff;
   assign rsp_freed_valid   = rsp_freed_valid_ff;
   assign rsp_freed_addr    = rsp_freed_addr_ff;
   assign rsp_live_entries  = rsp_live_ff;
   assign rsp_dropped_count = rsp_dropped_ff;

   // live counter tracks the valid bits
   a_live_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(live_ff))
      else $error("live count out of step with valid bits");

   // a swept entry always leaves a free slot for the insert
   a_freed_gives_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.insert && freed_ff) |-> slot_found_ff)
      else $error("entry freed but no free slot recorded");

   // never overwrite a pending result
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while pending");

   // saturation can only come from an assign
   a_sat_only_assign: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && sat_ff) |-> is_assign)
      else $error("saturation flagged outside assign");

endmodule
